### hdl/work_break_cycle_timer_defines.svh
// Assertion macros for the work/break cycle timer.
// Used by the top level only; needs nothing else.
`ifndef WORK_BREAK_CYCLE_TIMER_DEFINES_SVH
`define WORK_BREAK_CYCLE_TIMER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define WBCT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define WBCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/wbct_pkg.sv
// Package for the work/break cycle timer: item types, codes, register defaults
// and button geometry. No dependencies.
`default_nettype none

package wbct_pkg;

  localparam int CFG_DATA_W   = 24;
  localparam int CFG_IDX_W    = 2;
  localparam int ROUND_W      = 4;
  localparam int TICK_BITS_DEF = 24;

  localparam logic [CFG_DATA_W-1:0] WORK_TICKS_RST  = 24'd25000;
  localparam logic [CFG_DATA_W-1:0] SHORT_TICKS_RST = 24'd5000;
  localparam logic [CFG_DATA_W-1:0] LONG_TICKS_RST  = 24'd15000;
  localparam logic [ROUND_W-1:0]    ROUNDS_RST      = 4'd4;
  localparam logic [ROUND_W-1:0]    ROUND_MAX       = 4'd15;

  // Button strip, both ends inclusive
  localparam logic [8:0] BTN_Y_LO       = 9'd250;
  localparam logic [8:0] BTN_Y_HI       = 9'd290;
  localparam logic [7:0] BTN_START_X_LO = 8'd10;
  localparam logic [7:0] BTN_START_X_HI = 8'd80;
  localparam logic [7:0] BTN_PAUSE_X_LO = 8'd90;
  localparam logic [7:0] BTN_PAUSE_X_HI = 8'd160;
  localparam logic [7:0] BTN_RESET_X_LO = 8'd170;
  localparam logic [7:0] BTN_RESET_X_HI = 8'd240;

  typedef enum logic [0:0] {
    OP_TICK  = 1'b0,
    OP_TOUCH = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_WORK  = 2'd1,
    PH_BREAK = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_PAUSED  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    BTN_START = 2'd0,
    BTN_PAUSE = 2'd1,
    BTN_RESET = 2'd2,
    BTN_NONE  = 2'd3
  } button_e;

  typedef enum logic [1:0] {
    EV_NONE       = 2'd0,
    EV_WORK_DONE  = 2'd1,
    EV_BREAK_DONE = 2'd2,
    EV_CYCLE_DONE = 2'd3
  } event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WORK   = 2'd0,
    CFG_SHORT  = 2'd1,
    CFG_LONG   = 2'd2,
    CFG_ROUNDS = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [0:0] op;
    logic [7:0] touch_x;
    logic [8:0] touch_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            screen;
    logic [1:0]            run_state;
    logic                  long_break;
    logic [ROUND_W-1:0]    rounds_done;
    logic [CFG_DATA_W-1:0] remaining_ticks;
    logic [1:0]            button_hit;
    logic [1:0]            phase_event;
  } out_item_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] work_ticks;
    logic [CFG_DATA_W-1:0] short_ticks;
    logic [CFG_DATA_W-1:0] long_ticks;
    logic [ROUND_W-1:0]    rounds_per_cycle;
  } cfg_t;

endpackage

`default_nettype wire

### hdl/work_break_cycle_timer.sv
// Work/break cycle timer, top level. An accepted item is held in the input
// register; the state update lies between it and the result register.
// Throughput: one item per cycle, unless the output is stalled by out_ready_i.
// Reset: phase start, timer stopped, counts cleared, registers to defaults.
// Depends on wbct_pkg, wbct_cfg, wbct_step and the assertion macro header.
`default_nettype none
`include "work_break_cycle_timer_defines.svh"

module work_break_cycle_timer #(
  parameter int TICK_BITS = wbct_pkg::TICK_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire wbct_pkg::in_item_t               in_item_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output wbct_pkg::out_item_t                   out_item_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [wbct_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [wbct_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  logic                 in_valid_q;
  wbct_pkg::in_item_t   in_item_q;
  logic                 out_valid_q;
  wbct_pkg::out_item_t  out_item_q;
  wbct_pkg::out_item_t  result;
  wbct_pkg::cfg_t       cfg;
  logic                 advance;
  logic                 fire;

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  wbct_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  wbct_step #(
    .TICK_BITS (TICK_BITS)
  ) u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_item_q <= in_item_i;
    if (fire) out_item_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `WBCT_ASSERT_NEXT(a_fire_fills_out, clk_i, rst_ni, fire, out_valid_q,
                    "item left the input register without reaching the result register")
  `WBCT_ASSERT_NOW(a_start_stopped, clk_i, rst_ni,
                   out_valid_q && out_item_q.screen == wbct_pkg::PH_START,
                   out_item_q.run_state == wbct_pkg::MODE_STOPPED,
                   "timer running on the start screen")
  `WBCT_ASSERT_NOW(a_stopped_zero, clk_i, rst_ni,
                   out_valid_q && out_item_q.run_state == wbct_pkg::MODE_STOPPED,
                   out_item_q.remaining_ticks == '0,
                   "remaining ticks shown while stopped")
  `WBCT_ASSERT_NOW(a_event_stops, clk_i, rst_ni,
                   out_valid_q && out_item_q.phase_event != wbct_pkg::EV_NONE,
                   out_item_q.run_state == wbct_pkg::MODE_STOPPED,
                   "phase ended but timer not stopped")

endmodule

`default_nettype wire

### hdl/wbct_cfg.sv
// Configuration register file of the work/break cycle timer.
// Depends on wbct_pkg.
`default_nettype none

module wbct_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [wbct_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [wbct_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output wbct_pkg::cfg_t                        cfg_o
);

  wbct_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (wbct_pkg::cfg_idx_e'(cfg_idx_i))
        wbct_pkg::CFG_WORK:   cfg_d.work_ticks       = cfg_data_i;
        wbct_pkg::CFG_SHORT:  cfg_d.short_ticks      = cfg_data_i;
        wbct_pkg::CFG_LONG:   cfg_d.long_ticks       = cfg_data_i;
        wbct_pkg::CFG_ROUNDS: cfg_d.rounds_per_cycle = cfg_data_i[wbct_pkg::ROUND_W-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.work_ticks       <= wbct_pkg::WORK_TICKS_RST;
      cfg_q.short_ticks      <= wbct_pkg::SHORT_TICKS_RST;
      cfg_q.long_ticks       <= wbct_pkg::LONG_TICKS_RST;
      cfg_q.rounds_per_cycle <= wbct_pkg::ROUNDS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hdl/wbct_hit.sv
// Touch hit test against the start, pause and reset buttons.
// Depends on wbct_pkg.
`default_nettype none

module wbct_hit (
  input  wire logic [7:0]  touch_x_i,
  input  wire logic [8:0]  touch_y_i,
  output wbct_pkg::button_e button_o
);

  logic in_strip;

  assign in_strip = (touch_y_i >= wbct_pkg::BTN_Y_LO) && (touch_y_i <= wbct_pkg::BTN_Y_HI);

  always_comb begin
    priority if (in_strip && touch_x_i >= wbct_pkg::BTN_START_X_LO
                 && touch_x_i <= wbct_pkg::BTN_START_X_HI) begin
      button_o = wbct_pkg::BTN_START;
    end else if (in_strip && touch_x_i >= wbct_pkg::BTN_PAUSE_X_LO
                 && touch_x_i <= wbct_pkg::BTN_PAUSE_X_HI) begin
      button_o = wbct_pkg::BTN_PAUSE;
    end else if (in_strip && touch_x_i >= wbct_pkg::BTN_RESET_X_LO
                 && touch_x_i <= wbct_pkg::BTN_RESET_X_HI) begin
      button_o = wbct_pkg::BTN_RESET;
    end else begin
      button_o = wbct_pkg::BTN_NONE;
    end
  end

endmodule

`default_nettype wire

### hdl/wbct_step.sv
// Timer state and its per-item update: phase, run mode, long-break flag, round
// count and elapsed ticks. Depends on wbct_pkg and wbct_hit.
`default_nettype none

module wbct_step #(
  parameter int TICK_BITS = wbct_pkg::TICK_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                fire_i,
  input  wire wbct_pkg::in_item_t  item_i,
  input  wire wbct_pkg::cfg_t      cfg_i,
  output wbct_pkg::out_item_t      result_o
);

  localparam int DW = wbct_pkg::CFG_DATA_W;
  localparam int CW = (TICK_BITS > DW) ? TICK_BITS : DW;
  localparam int RW = wbct_pkg::ROUND_W;
  localparam logic [TICK_BITS-1:0] EL_MAX = {TICK_BITS{1'b1}};

  wbct_pkg::phase_e      phase_q, phase_d;
  wbct_pkg::mode_e       mode_q, mode_d;
  logic                  long_q, long_d;
  logic [RW-1:0]         rounds_q, rounds_d;
  logic [TICK_BITS-1:0]  elapsed_q, elapsed_d;

  wbct_pkg::button_e     hit;
  wbct_pkg::button_e     button;
  wbct_pkg::event_e      evt;
  logic [DW-1:0]         dur;
  logic [CW-1:0]         dur_w, el_w, rem_w;
  logic                  reached;
  logic [RW-1:0]         rounds_inc;
  logic                  touch;

  wbct_hit u_hit (
    .touch_x_i (item_i.touch_x),
    .touch_y_i (item_i.touch_y),
    .button_o  (hit)
  );

  assign touch = (item_i.op == wbct_pkg::OP_TOUCH);

  always_comb begin
    phase_d    = phase_q;
    mode_d     = mode_q;
    long_d     = long_q;
    rounds_d   = rounds_q;
    elapsed_d  = elapsed_q;
    button     = wbct_pkg::BTN_NONE;
    evt        = wbct_pkg::EV_NONE;
    rounds_inc = (rounds_q != wbct_pkg::ROUND_MAX) ? rounds_q + RW'(1) : rounds_q;

    if (phase_q == wbct_pkg::PH_START) begin
      if (touch) phase_d = wbct_pkg::PH_WORK;
    end else if (touch) begin
      button = hit;
      unique case (hit)
        wbct_pkg::BTN_START: begin
          if (mode_q == wbct_pkg::MODE_STOPPED) begin
            elapsed_d = '0;
            mode_d    = wbct_pkg::MODE_RUNNING;
          end else if (mode_q == wbct_pkg::MODE_PAUSED) begin
            mode_d = wbct_pkg::MODE_RUNNING;
          end
        end
        wbct_pkg::BTN_PAUSE: begin
          if (mode_q == wbct_pkg::MODE_RUNNING) mode_d = wbct_pkg::MODE_PAUSED;
        end
        wbct_pkg::BTN_RESET: begin
          mode_d    = wbct_pkg::MODE_STOPPED;
          elapsed_d = '0;
        end
        default: ;
      endcase
    end else if (mode_q == wbct_pkg::MODE_RUNNING && elapsed_q != EL_MAX) begin
      elapsed_d = elapsed_q + TICK_BITS'(1);
    end

    // duration of the phase as it stood before this item
    dur     = (phase_q == wbct_pkg::PH_WORK) ? cfg_i.work_ticks
            : (long_q ? cfg_i.long_ticks : cfg_i.short_ticks);
    dur_w   = CW'(dur);
    el_w    = CW'(elapsed_d);
    reached = (el_w >= dur_w);

    if (phase_q != wbct_pkg::PH_START && mode_d == wbct_pkg::MODE_RUNNING && reached) begin
      mode_d    = wbct_pkg::MODE_STOPPED;
      elapsed_d = '0;
      if (phase_q == wbct_pkg::PH_WORK) begin
        rounds_d = rounds_inc;
        long_d   = (rounds_inc >= cfg_i.rounds_per_cycle);
        phase_d  = wbct_pkg::PH_BREAK;
        evt      = wbct_pkg::EV_WORK_DONE;
      end else if (rounds_q >= cfg_i.rounds_per_cycle) begin
        rounds_d = '0;
        long_d   = 1'b0;
        phase_d  = wbct_pkg::PH_START;
        evt      = wbct_pkg::EV_CYCLE_DONE;
      end else begin
        phase_d = wbct_pkg::PH_WORK;
        evt     = wbct_pkg::EV_BREAK_DONE;
      end
    end

    // without completion the phase is unchanged, so the same duration holds
    rem_w = '0;
    if (mode_d != wbct_pkg::MODE_STOPPED && phase_d != wbct_pkg::PH_START && !reached) begin
      rem_w = dur_w - el_w;
    end

    result_o.screen          = phase_d;
    result_o.run_state       = mode_d;
    result_o.long_break      = long_d;
    result_o.rounds_done     = rounds_d;
    result_o.remaining_ticks = DW'(rem_w);
    result_o.button_hit      = button;
    result_o.phase_event     = evt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= wbct_pkg::PH_START;
      mode_q    <= wbct_pkg::MODE_STOPPED;
      long_q    <= 1'b0;
      rounds_q  <= '0;
      elapsed_q <= '0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      mode_q    <= mode_d;
      long_q    <= long_d;
      rounds_q  <= rounds_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule

`default_nettype wire
